// ===== design/tcw_pkg.sv =====
// shared types and constants for the text console character writer
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    // field widths
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int OFF_W  = 11;
    localparam int CELL_W = 16;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int SCAN_W = $clog2(CELLS + 1);

    // tab stops every eight columns
    localparam int TAB_STOP = 8;
    localparam int TAB_W    = $clog2(TAB_STOP);

    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
    localparam logic [OFF_W-1:0]  OFF_COLS   = OFF_W'(COLUMNS);
    localparam logic [OFF_W-1:0]  OFF_WRAP   = OFF_W'(COLUMNS - 1);
    localparam logic [OFF_W-1:0]  OFF_HOME   = OFF_W'(CELLS - COLUMNS);
    localparam logic [SCAN_W-1:0] SCAN_START = SCAN_W'(COLUMNS);
    localparam logic [SCAN_W-1:0] SCAN_END   = SCAN_W'(CELLS);
    localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(CELLS - 1);

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [CELL_W-1:0] CELL_RESET = {ATTR_RESET, BLANK_CHAR};

    // commands
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // control codes
    localparam logic [CHAR_W-1:0] CHAR_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_STORE,
        S_SCROLL,
        S_FILL,
        S_RDWAIT,
        S_DONE
    } state_t;

endpackage

// ===== design/text_console_character_writer.sv =====
// text console: screen store, cursor sequencer and stream ports
// the result is registered; a tab stores up to 8 blanks
// a scroll makes one walk of the store through the single read and single write port of
// the screen memory, bottom row blanks included
// throughput: one item at a time, ready again in the cycle its result goes out
// reset: async, active low; a clearing pass over all CELLS (2000) cells blanks the store to 0x0720
module text_console_character_writer
    import tcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // attribute register write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,      // text_attribute
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // char_code[7:0], cell_index[18:8], zero pad
    input  logic [0:0]  s_tuser,       // cmd[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata        // cursor_row[4:0], cursor_col[11:5],
                                       // cursor_offset[22:12], cell_value[38:23], zero pad
);

    // sequencer state
    state_t state_reg, state_next;

    // latched command beat
    logic              cmd_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [OFF_W-1:0]  idx_reg;

    // attribute register
    logic [ATTR_W-1:0] attr_reg;

    // cursor
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [OFF_W-1:0]  off_reg, off_next;

    // scroll / clear walkers
    logic [SCAN_W-1:0] scan_reg, scan_next;
    logic [ADDR_W-1:0] dst_reg, dst_next;
    logic              pipe_reg, pipe_next;

    // read value held for the result
    logic [CELL_W-1:0] val_reg, val_next;

    // result register
    logic              m_tvalid_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [OFF_W-1:0]  out_off_reg;
    logic [CELL_W-1:0] out_val_reg;
    logic              out_free;

    // screen memory
    logic [CELL_W-1:0] mem [CELLS];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] rd_data_reg;

    // shared cursor adder: offset + operand + carry in
    logic [OFF_W-1:0]  add_b;
    logic              add_cin;
    logic [OFF_W-1:0]  add_sum;

    // helpers
    logic [COL_W-1:0]  col_inc;
    logic [ROW_W-1:0]  row_inc;
    logic              is_tab;
    logic              at_col_end;
    logic              at_row_end;
    logic              idx_ok;
    logic [CELL_W-1:0] blank_cell;

    assign add_sum    = off_reg + add_b + OFF_W'(add_cin);
    assign col_inc    = col_reg + 1'b1;
    assign row_inc    = row_reg + 1'b1;
    assign is_tab     = (char_reg == CHAR_TAB);
    assign at_col_end = (col_reg == COL_LAST);
    assign at_row_end = (row_reg == ROW_LAST);
    assign idx_ok     = (idx_reg < OFF_W'(CELLS));
    assign blank_cell = {attr_reg, BLANK_CHAR};
    assign out_free   = !m_tvalid_reg || m_tready;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {1'b0, out_val_reg, out_off_reg, out_col_reg, out_row_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (dst_reg == ADDR_LAST)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (cmd_reg == CMD_READ)
                    state_next = idx_ok ? S_RDWAIT : S_DONE;
                else
                begin
                    case (char_reg) inside
                        CHAR_CR, CHAR_BS: state_next = S_DONE;
                        CHAR_LF:          state_next = at_row_end ? S_SCROLL : S_DONE;
                        default:          state_next = S_STORE;
                    endcase
                end
            end
            S_STORE:
            begin
                if (at_col_end)
                    state_next = at_row_end ? S_SCROLL : S_DONE;
                else if (is_tab && (col_inc[TAB_W-1:0] != '0))
                    state_next = S_STORE;
                else
                    state_next = S_DONE;
            end
            S_SCROLL:
            begin
                if (scan_reg == SCAN_END)
                    state_next = S_FILL;
            end
            S_FILL:
            begin
                if (dst_reg == ADDR_LAST)
                    state_next = S_DONE;
            end
            S_RDWAIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath controls
    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        off_next  = off_reg;
        scan_next = scan_reg;
        dst_next  = dst_reg;
        pipe_next = 1'b0;
        val_next  = val_reg;
        add_b     = OFF_W'(1);
        add_cin   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = off_reg[ADDR_W-1:0];
        mem_wdata = blank_cell;
        mem_re    = 1'b0;
        mem_raddr = idx_reg[ADDR_W-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = dst_reg;
                mem_wdata = CELL_RESET;
                dst_next  = dst_reg + 1'b1;
            end
            S_EXEC:
            begin
                val_next = '0;
                if (cmd_reg == CMD_READ)
                    mem_re = idx_ok;
                else
                begin
                    case (char_reg)
                        CHAR_CR:
                        begin
                            // offset minus column
                            add_b    = ~OFF_W'(col_reg);
                            add_cin  = 1'b1;
                            off_next = add_sum;
                            col_next = '0;
                        end
                        CHAR_LF:
                        begin
                            if (at_row_end)
                            begin
                                scan_next = SCAN_START;
                                dst_next  = '0;
                            end
                            else
                            begin
                                add_b    = OFF_COLS;
                                off_next = add_sum;
                                row_next = row_inc;
                            end
                        end
                        CHAR_BS:
                        begin
                            if (col_reg != '0)
                            begin
                                add_b     = '1;
                                off_next  = add_sum;
                                col_next  = col_reg - 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = add_sum[ADDR_W-1:0];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_STORE:
            begin
                mem_we    = 1'b1;
                mem_wdata = is_tab ? blank_cell : {attr_reg, char_reg};
                if (at_col_end)
                begin
                    col_next = '0;
                    if (at_row_end)
                    begin
                        // back to the start of the bottom row
                        add_b     = ~OFF_WRAP;
                        add_cin   = 1'b1;
                        scan_next = SCAN_START;
                        dst_next  = '0;
                    end
                    else
                        row_next = row_inc;
                end
                else
                    col_next = col_inc;
                off_next = add_sum;
            end
            S_SCROLL:
            begin
                // read one row below, write it back from the read data register
                if (pipe_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg;
                    mem_wdata = rd_data_reg;
                    dst_next  = dst_reg + 1'b1;
                end
                if (scan_reg != SCAN_END)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = scan_reg[ADDR_W-1:0];
                    scan_next = scan_reg + 1'b1;
                    pipe_next = 1'b1;
                end
            end
            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = dst_reg;
                dst_next  = dst_reg + 1'b1;
            end
            S_RDWAIT:
            begin
                val_next = rd_data_reg;
            end
            default:
            begin
            end
        endcase
    end

    // screen memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    // command beat capture
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg  <= s_tuser[0];
            char_reg <= s_tdata[7:0];
            idx_reg  <= s_tdata[18:8];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        scan_reg  <= scan_next;
        val_reg   <= val_next;
        if (state_reg == S_DONE && out_free)
        begin
            out_row_reg <= row_reg;
            out_col_reg <= col_reg;
            out_off_reg <= off_reg;
            out_val_reg <= val_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            attr_reg     <= ATTR_RESET;
            row_reg      <= ROW_LAST;
            col_reg      <= '0;
            off_reg      <= OFF_HOME;
            dst_reg      <= '0;
            pipe_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            off_reg   <= off_next;
            dst_reg   <= dst_next;
            pipe_reg  <= pipe_next;
            if (cfg_valid && cfg_ready)
                attr_reg <= cfg_data;
            if (state_reg == S_DONE && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // cursor offset tracks row and column from reset
    // (row_reg at bottom, column 0 gives the bottom row start)
endmodule
